// File: src/dles_pkg.sv
`timescale 1ns / 1ps
package dles_pkg;

  localparam logic [2:0] KIND_LOAD_DELAY = 3'd0;
  localparam logic [2:0] KIND_LOAD_ATTR  = 3'd1;
  localparam logic [2:0] KIND_RESET      = 3'd2;
  localparam logic [2:0] KIND_CORRECT    = 3'd3;
  localparam logic [2:0] KIND_BUILD      = 3'd4;
  localparam logic [2:0] KIND_FIRE       = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_BAD_LOC  = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic [1:0] RK_ACK   = 2'd0;
  localparam logic [1:0] RK_EVENT = 2'd1;
  localparam logic [1:0] RK_ARM   = 2'd2;
  localparam logic [1:0] RK_END   = 2'd3;

  localparam logic [5:0]  NO_LOC       = 6'd63;
  localparam logic [15:0] UNUSED_DELAY = 16'hFFFF;
  localparam logic [15:0] MAX_DELAY    = 16'hFFFE;

endpackage

// File: src/dles_ram.sv
`timescale 1ns / 1ps
module dles_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: src/delta_list_event_scheduler.sv
`timescale 1ns / 1ps
// Delta-list event scheduler. An item is taken when start is high and busy is low; the
// block then stays busy until its last result has been sent. Every result is shown for one
// cycle with result_valid_o and must be taken then, since the receiver cannot stall. Loads
// and corrections write the tables directly, a correction after reading the nominal delay.
// A reset item sweeps all location/slot entries, copying each nominal delay to the working
// delay and clearing its link. A build item walks each list through the tables, which have
// one read port each. A fire item follows at most NUM_LOCATIONS links.
module delta_list_event_scheduler #(
  parameter int NUM_LOCATIONS = 32,
  parameter int NUM_SLOTS     = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [5:0]  location_i,
  input  logic [2:0]  slot_i,
  input  logic [15:0] delay_value_i,
  input  logic signed [15:0] offset_i,
  input  logic [5:0]  trigger_location_i,
  input  logic [31:0] mask_i,
  input  logic [15:0] sheet_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [1:0]  result_kind_o,
  output logic [5:0]  result_location_o,
  output logic [15:0] result_sheet_o,
  output logic [15:0] arm_delay_o,
  output logic        last_o
);

  localparam int LW = (NUM_LOCATIONS > 1) ? $clog2(NUM_LOCATIONS) : 1;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int AW = LW + SW;
  localparam int LS_DEPTH = 2 ** AW;
  localparam int L_DEPTH = 2 ** LW;
  localparam logic [5:0] NL6 = 6'(NUM_LOCATIONS);
  localparam logic [5:0] LAST_LOC = 6'(NUM_LOCATIONS - 1);
  localparam logic [3:0] NS4 = 4'(NUM_SLOTS);
  localparam logic [2:0] LAST_SLOT = 3'(NUM_SLOTS - 1);
  localparam logic signed [17:0] MAX_T = 18'sd65534;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_COR     = 5'd2;
  localparam logic [4:0] S_RST_RD  = 5'd3;
  localparam logic [4:0] S_RST_WR  = 5'd4;
  localparam logic [4:0] S_B_RD    = 5'd5;
  localparam logic [4:0] S_B_CHK   = 5'd6;
  localparam logic [4:0] S_B_LNK   = 5'd7;
  localparam logic [4:0] S_B_CMP   = 5'd8;
  localparam logic [4:0] S_B_FIX   = 5'd9;
  localparam logic [4:0] S_B_INS   = 5'd10;
  localparam logic [4:0] S_B_INS2  = 5'd11;
  localparam logic [4:0] S_F_CHK   = 5'd12;
  localparam logic [4:0] S_N_ISS   = 5'd13;
  localparam logic [4:0] S_N_LNK   = 5'd14;
  localparam logic [4:0] S_N_W     = 5'd15;

  function automatic logic [AW-1:0] ls_addr(input logic [5:0] l, input logic [2:0] s);
    ls_addr = {l[LW-1:0], s[SW-1:0]};
  endfunction

  function automatic logic [5:0] map_loc(input logic [5:0] v);
    map_loc = (v < NL6) ? v : dles_pkg::NO_LOC;
  endfunction

  logic [4:0]  state_q, state_d;
  logic        en_q, en_d;
  logic [2:0]  kind_q;
  logic [5:0]  loc_q, trig_q;
  logic [2:0]  slot_q;
  logic [15:0] dval_q, off_q, sheet_q;
  logic [31:0] mask_q;
  logic [5:0]  cur_q, cur_d, nxt_q, nxt_d, bud_q, bud_d, cl_q, cl_d;
  logic [2:0]  cs_q, cs_d;
  logic [15:0] dly_q, dly_d, wnx_q, wnx_d, acc_q, acc_d;

  logic        ov_q;
  logic [1:0]  ost_q, ork_q;
  logic [5:0]  oloc_q;
  logic [15:0] osh_q, oad_q;
  logic        olast_q;

  logic        emit;
  logic [1:0]  e_st, e_rk;
  logic [5:0]  e_loc;
  logic [15:0] e_sh, e_ad;
  logic        e_last;

  logic          nom_we, wd_we, lnk_we, attr_we;
  logic [AW-1:0] nom_waddr, nom_raddr, wd_waddr, wd_raddr, lnk_waddr, lnk_raddr;
  logic [LW-1:0] attr_waddr, trg_raddr, flt_raddr;
  logic [15:0]   nom_wdata, nom_rd, wd_wdata, wd_rd;
  logic [5:0]    lnk_wdata, lnk_rd, trg_rd;
  logic [31:0]   flt_rd;

  logic        accept;
  logic        loc_ok, slot_ok, last_pair;
  logic [5:0]  n_loc;
  logic [16:0] sum17;
  logic [15:0] sum_sat;
  logic signed [17:0] cor_t;

  dles_ram #(.WIDTH(16), .DEPTH(LS_DEPTH)) u_nom (
    .clk_i, .we_i(nom_we), .waddr_i(nom_waddr), .wdata_i(nom_wdata),
    .raddr_i(nom_raddr), .rdata_o(nom_rd)
  );
  dles_ram #(.WIDTH(16), .DEPTH(LS_DEPTH)) u_wd (
    .clk_i, .we_i(wd_we), .waddr_i(wd_waddr), .wdata_i(wd_wdata),
    .raddr_i(wd_raddr), .rdata_o(wd_rd)
  );
  dles_ram #(.WIDTH(6), .DEPTH(LS_DEPTH)) u_lnk (
    .clk_i, .we_i(lnk_we), .waddr_i(lnk_waddr), .wdata_i(lnk_wdata),
    .raddr_i(lnk_raddr), .rdata_o(lnk_rd)
  );
  dles_ram #(.WIDTH(6), .DEPTH(L_DEPTH)) u_trg (
    .clk_i, .we_i(attr_we), .waddr_i(attr_waddr), .wdata_i(trig_q),
    .raddr_i(trg_raddr), .rdata_o(trg_rd)
  );
  dles_ram #(.WIDTH(32), .DEPTH(L_DEPTH)) u_flt (
    .clk_i, .we_i(attr_we), .waddr_i(attr_waddr), .wdata_i(mask_q),
    .raddr_i(flt_raddr), .rdata_o(flt_rd)
  );

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign loc_ok  = (loc_q < NL6);
  assign slot_ok = ({1'b0, slot_q} < NS4);
  assign last_pair = (cl_q == LAST_LOC) && (cs_q == LAST_SLOT);
  assign n_loc   = map_loc(lnk_rd);
  assign sum17   = {1'b0, acc_q} + {1'b0, wd_rd};
  assign sum_sat = sum17[16] ? 16'hFFFF : sum17[15:0];
  assign cor_t   = $signed({2'b00, nom_rd}) + $signed({{2{off_q[15]}}, off_q});

  always_comb begin
    state_d = state_q;
    en_d = en_q;
    cur_d = cur_q; nxt_d = nxt_q; bud_d = bud_q; cl_d = cl_q; cs_d = cs_q;
    dly_d = dly_q; wnx_d = wnx_q; acc_d = acc_q;
    emit = 1'b0;
    e_st = dles_pkg::ST_OK; e_rk = dles_pkg::RK_ACK; e_loc = dles_pkg::NO_LOC;
    e_sh = 16'd0; e_ad = 16'd0; e_last = 1'b1;
    nom_we = 1'b0; nom_waddr = ls_addr(loc_q, slot_q); nom_wdata = dval_q;
    nom_raddr = ls_addr(loc_q, slot_q);
    wd_we = 1'b0; wd_waddr = ls_addr(cl_q, cs_q); wd_wdata = dly_q;
    wd_raddr = ls_addr(cl_q, cs_q);
    lnk_we = 1'b0; lnk_waddr = ls_addr(cl_q, cs_q); lnk_wdata = dles_pkg::NO_LOC;
    lnk_raddr = ls_addr(cur_q, slot_q);
    attr_we = 1'b0; attr_waddr = loc_q[LW-1:0];
    trg_raddr = cl_q[LW-1:0]; flt_raddr = loc_q[LW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_IDLE;
        cl_d = 6'd0;
        cs_d = 3'd0;
        unique case (kind_q)
          dles_pkg::KIND_LOAD_DELAY: begin
            emit = 1'b1;
            if (!loc_ok) begin
              e_st = dles_pkg::ST_BAD_LOC;
            end else if (!slot_ok) begin
              e_st = dles_pkg::ST_IGNORED;
            end else begin
              nom_we = 1'b1;
            end
          end
          dles_pkg::KIND_LOAD_ATTR: begin
            emit = 1'b1;
            if (!loc_ok) begin
              e_st = dles_pkg::ST_BAD_LOC;
            end else begin
              attr_we = 1'b1;
            end
          end
          dles_pkg::KIND_RESET: begin
            if (en_q) begin
              emit = 1'b1;
              e_st = dles_pkg::ST_IGNORED;
            end else begin
              state_d = S_RST_RD;
            end
          end
          dles_pkg::KIND_CORRECT: begin
            if (!en_q) begin
              emit = 1'b1;
              e_st = dles_pkg::ST_DISABLED;
            end else if (!loc_ok) begin
              emit = 1'b1;
              e_st = dles_pkg::ST_BAD_LOC;
            end else if (!slot_ok) begin
              emit = 1'b1;
              e_st = dles_pkg::ST_IGNORED;
            end else begin
              state_d = S_COR;
            end
          end
          dles_pkg::KIND_BUILD: begin
            if (!en_q) begin
              emit = 1'b1;
              e_st = dles_pkg::ST_DISABLED;
            end else begin
              en_d = 1'b0;
              state_d = S_B_RD;
            end
          end
          dles_pkg::KIND_FIRE: begin
            if (!loc_ok) begin
              emit = 1'b1;
              e_st = dles_pkg::ST_BAD_LOC;
            end else if (!slot_ok) begin
              emit = 1'b1;
              e_st = dles_pkg::ST_IGNORED;
            end else begin
              state_d = S_F_CHK;
            end
          end
          default: begin
            emit = 1'b1;
            e_st = dles_pkg::ST_IGNORED;
          end
        endcase
      end
      S_COR: begin
        emit = 1'b1;
        state_d = S_IDLE;
        if (nom_rd != dles_pkg::UNUSED_DELAY) begin
          wd_we = 1'b1;
          wd_waddr = ls_addr(loc_q, slot_q);
          if (cor_t[17]) begin
            wd_wdata = 16'd0;
          end else if (cor_t > MAX_T) begin
            wd_wdata = dles_pkg::MAX_DELAY;
          end else begin
            wd_wdata = cor_t[15:0];
          end
        end
      end
      S_RST_RD: begin
        nom_raddr = ls_addr(cl_q, cs_q);
        state_d = S_RST_WR;
      end
      S_RST_WR: begin
        wd_we = 1'b1;
        wd_wdata = nom_rd;
        lnk_we = 1'b1;
        if (last_pair) begin
          en_d = 1'b1;
          emit = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_RST_RD;
          if (cs_q == LAST_SLOT) begin
            cs_d = 3'd0;
            cl_d = cl_q + 6'd1;
          end else begin
            cs_d = cs_q + 3'd1;
          end
        end
      end
      S_B_RD: begin
        state_d = S_B_CHK;
      end
      S_B_CHK: begin
        dly_d = wd_rd;
        cur_d = trg_rd;
        bud_d = NL6;
        lnk_raddr = ls_addr(trg_rd, cs_q);
        if (trg_rd >= NL6 || wd_rd == dles_pkg::UNUSED_DELAY) begin
          if (last_pair) begin
            emit = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_B_RD;
            if (cs_q == LAST_SLOT) begin
              cs_d = 3'd0;
              cl_d = cl_q + 6'd1;
            end else begin
              cs_d = cs_q + 3'd1;
            end
          end
        end else begin
          state_d = S_B_LNK;
        end
      end
      S_B_LNK: begin
        nxt_d = n_loc;
        wd_raddr = ls_addr(n_loc, cs_q);
        if (n_loc == dles_pkg::NO_LOC) begin
          state_d = S_B_INS;
        end else if (bud_q != 6'd0) begin
          bud_d = bud_q - 6'd1;
          state_d = S_B_CMP;
        end else begin
          state_d = S_B_FIX;
        end
      end
      S_B_CMP: begin
        if (wd_rd <= dly_q) begin
          dly_d = dly_q - wd_rd;
          cur_d = nxt_q;
          lnk_raddr = ls_addr(nxt_q, cs_q);
          state_d = S_B_LNK;
        end else begin
          wnx_d = wd_rd;
          state_d = S_B_INS;
        end
      end
      S_B_FIX: begin
        wnx_d = wd_rd;
        state_d = S_B_INS;
      end
      S_B_INS: begin
        lnk_we = 1'b1;
        lnk_waddr = ls_addr(cur_q, cs_q);
        lnk_wdata = cl_q;
        wd_we = 1'b1;
        state_d = S_B_INS2;
      end
      S_B_INS2: begin
        lnk_we = 1'b1;
        lnk_wdata = nxt_q;
        if (nxt_q != dles_pkg::NO_LOC) begin
          wd_we = 1'b1;
          wd_waddr = ls_addr(nxt_q, cs_q);
          wd_wdata = ((nxt_q == cl_q) ? dly_q : wnx_q) - dly_q;
        end
        if (last_pair) begin
          emit = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_B_RD;
          if (cs_q == LAST_SLOT) begin
            cs_d = 3'd0;
            cl_d = cl_q + 6'd1;
          end else begin
            cs_d = cs_q + 3'd1;
          end
        end
      end
      S_F_CHK: begin
        cur_d = loc_q;
        acc_d = 16'd0;
        bud_d = NL6;
        state_d = S_N_ISS;
        if ((flt_rd & mask_q) != 32'd0) begin
          emit = 1'b1;
          e_rk = dles_pkg::RK_EVENT;
          e_loc = loc_q;
          e_sh = sheet_q;
          e_last = 1'b0;
        end
      end
      S_N_ISS: begin
        if (bud_q == 6'd0) begin
          emit = 1'b1;
          e_rk = dles_pkg::RK_END;
          e_sh = sheet_q;
          e_ad = 16'hFFFF;
          state_d = S_IDLE;
        end else begin
          bud_d = bud_q - 6'd1;
          state_d = S_N_LNK;
        end
      end
      S_N_LNK: begin
        nxt_d = n_loc;
        wd_raddr = ls_addr(n_loc, slot_q);
        flt_raddr = n_loc[LW-1:0];
        if (n_loc == dles_pkg::NO_LOC) begin
          emit = 1'b1;
          e_rk = dles_pkg::RK_END;
          e_sh = sheet_q;
          e_ad = 16'hFFFF;
          state_d = S_IDLE;
        end else begin
          state_d = S_N_W;
        end
      end
      S_N_W: begin
        cur_d = nxt_q;
        state_d = S_N_ISS;
        if ((flt_rd & mask_q) != 32'd0) begin
          emit = 1'b1;
          e_loc = nxt_q;
          e_sh = sheet_q;
          if (sum_sat != 16'd0) begin
            e_rk = dles_pkg::RK_ARM;
            e_ad = sum_sat;
            state_d = S_IDLE;
          end else begin
            e_rk = dles_pkg::RK_EVENT;
            e_last = 1'b0;
            acc_d = 16'd0;
          end
        end else begin
          acc_d = sum_sat;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      en_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      en_q <= en_d;
      ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      loc_q <= location_i;
      slot_q <= slot_i;
      dval_q <= delay_value_i;
      off_q <= offset_i;
      trig_q <= trigger_location_i;
      mask_q <= mask_i;
      sheet_q <= sheet_i;
    end
    cur_q <= cur_d; nxt_q <= nxt_d; bud_q <= bud_d; cl_q <= cl_d; cs_q <= cs_d;
    dly_q <= dly_d; wnx_q <= wnx_d; acc_q <= acc_d;
    ost_q <= e_st; ork_q <= e_rk; oloc_q <= e_loc;
    osh_q <= e_sh; oad_q <= e_ad; olast_q <= e_last;
  end

  assign result_valid_o    = ov_q;
  assign status_o          = ost_q;
  assign result_kind_o     = ork_q;
  assign result_location_o = oloc_q;
  assign result_sheet_o    = osh_q;
  assign arm_delay_o       = oad_q;
  assign last_o            = olast_q;

  // arm timer and chain end words always close an item, events never do
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_kind_o == dles_pkg::RK_ARM || result_kind_o == dles_pkg::RK_END)
    |-> last_o)
    else $error("arm or chain end word without last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == dles_pkg::RK_EVENT |-> !last_o)
    else $error("event word marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !result_valid_o)
    else $error("accepted word not processed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("item ended before its last word");

endmodule
